// ----- rtl/core/spp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, widths and codes of the screen polyline pick unit.
// ----------------------------------------------------------------------------
package spp_pkg;

    // field widths
    localparam int COORD_W   = 13;
    localparam int EDGE_W    = 10;
    localparam int TOL_W     = 12;
    localparam int INDEX_W   = 11;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // arithmetic widths
    localparam int DIFF_W = COORD_W + 1;     // difference of two coordinates
    localparam int MUL_W  = 2 * DIFF_W;      // product of two differences
    localparam int PROD_W = MUL_W + 1;       // sum of two products
    localparam int SQ_W   = 27;              // squared length, |cross|, |q|^2
    localparam int NUM_W  = 2 * SQ_W;        // distance numerator
    localparam int DEN_W  = SQ_W;            // distance denominator
    localparam int HALF_W = SQ_W;            // numerator split for the compare
    localparam int PP_W   = HALF_W + DEN_W;  // partial product
    localparam int WIDE_W = NUM_W + DEN_W;   // full cross product of the compare

    // decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [MUL_W-1:0]   mul_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic        [SQ_W-1:0]    sq_t;
    typedef logic        [NUM_W-1:0]   num_t;
    typedef logic        [DEN_W-1:0]   den_t;
    typedef logic        [PP_W-1:0]    pp_t;
    typedef logic        [WIDE_W-1:0]  wide_t;
    typedef logic signed [INDEX_W-1:0] index_t;

    localparam den_t   DEN_ONE    = den_t'(1);
    localparam index_t INDEX_NONE = '1;   // -1: nothing picked

    // configuration as seen by the back end
    typedef struct packed {
        coord_t            query_x;
        coord_t            query_y;
        logic [TOL_W-1:0]  tolerance;
    } spp_cfg_t;

    // one unit of work for the back end
    typedef struct packed {
        logic              pick_start;
        logic              pick_end;
        logic              seg;
        logic [EDGE_W-1:0] edge_id;
        coord_t            sx;
        coord_t            sy;
        coord_t            ex;
        coord_t            ey;
    } spp_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SEL,
        ST_SQ,
        ST_MUL,
        ST_SUM,
        ST_CMP,
        ST_EMIT
    } spp_state_t;

endpackage

// ----- rtl/core/spp_vertex_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_vertex_if
// Vertex channel: valid/ready handshake with one projected vertex as payload.
// ----------------------------------------------------------------------------
interface spp_vertex_if;
    logic                        valid;
    logic                        ready;
    spp_pkg::coord_t             vertex_x;
    spp_pkg::coord_t             vertex_y;
    logic [spp_pkg::EDGE_W-1:0]  edge_id;
    logic                        visible;
    logic                        edge_start;
    logic                        pick_start;
    logic                        pick_end;

    modport source (
        output valid, vertex_x, vertex_y, edge_id, visible, edge_start,
               pick_start, pick_end,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, edge_id, visible, edge_start,
               pick_start, pick_end,
        output ready
    );
endinterface

// ----- rtl/core/spp_pick_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pick_if
// Result channel: valid/ready handshake with one pick result as payload.
// ----------------------------------------------------------------------------
interface spp_pick_if;
    logic             valid;
    logic             ready;
    logic             found;
    spp_pkg::index_t  near_edge;

    modport source (
        output valid, found, near_edge,
        input  ready
    );

    modport sink (
        input  valid, found, near_edge,
        output ready
    );
endinterface

// ----- rtl/core/spp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_front
// Accepts vertices, tracks the chain and emits segment / pick jobs.
// ----------------------------------------------------------------------------
module spp_front (
    input  logic              clk,
    input  logic              rst_n,
    spp_vertex_if.sink        vertex,
    output logic              push_valid,
    input  logic              push_ready,
    output spp_pkg::spp_job_t push_job
);

    spp_pkg::coord_t prev_x_reg, prev_x_next;
    spp_pkg::coord_t prev_y_reg, prev_y_next;
    logic            has_prev_reg, has_prev_next;
    logic            take;
    logic            chain;

    assign vertex.ready = push_ready;
    assign take         = vertex.valid & push_ready;

    // previous vertex counts only if neither a pick nor an edge starts here
    assign chain = has_prev_reg & ~vertex.pick_start & ~vertex.edge_start;

    // job payload
    always_comb
    begin
        push_job.pick_start = vertex.pick_start;
        push_job.pick_end   = vertex.pick_end;
        push_job.seg        = chain & vertex.visible;
        push_job.edge_id    = vertex.edge_id;
        push_job.sx         = prev_x_reg;
        push_job.sy         = prev_y_reg;
        push_job.ex         = vertex.vertex_x;
        push_job.ey         = vertex.vertex_y;
    end

    // vertices that neither close a segment nor bound a pick leave no job
    assign push_valid = vertex.valid
                      & (push_job.seg | vertex.pick_start | vertex.pick_end);

    // chain tracking: an invisible vertex breaks it, a visible one extends it
    always_comb
    begin
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        has_prev_next = has_prev_reg;
        if (take)
        begin
            has_prev_next = vertex.visible;
            if (vertex.visible)
            begin
                prev_x_next = vertex.vertex_x;
                prev_y_next = vertex.vertex_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            has_prev_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            has_prev_reg <= has_prev_next;
        end
    end

endmodule

// ----- rtl/core/spp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module spp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  spp_pkg::spp_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output spp_pkg::spp_job_t pop_job
);

    spp_pkg::spp_job_t                 slot_reg [spp_pkg::QUEUE_DEPTH];
    logic [spp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [spp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [spp_pkg::QUEUE_PTR_W:0]     count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg != (spp_pkg::QUEUE_PTR_W + 1)'(spp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (do_push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (do_pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (do_push & ~do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop & ~do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- rtl/core/spp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_back
// Segment distance, exact rational best compare and result output register.
// ----------------------------------------------------------------------------
module spp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  spp_pkg::spp_cfg_t cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  spp_pkg::spp_job_t pop_job,
    spp_pick_if.source        pick
);

    spp_pkg::spp_state_t state_reg, state_next;

    // job and datapath registers
    spp_pkg::spp_job_t   job_reg;
    spp_pkg::diff_t      dx_reg, dy_reg, qx_reg, qy_reg, rx_reg, ry_reg;
    spp_pkg::sq_t        len_reg, q2_reg, r2_reg, cabs_reg;
    spp_pkg::prod_t      dot_reg, cross_reg;
    spp_pkg::num_t       num_reg;
    spp_pkg::den_t       den_reg;
    spp_pkg::pp_t        p1lo_reg, p1hi_reg, p2lo_reg, p2hi_reg;
    spp_pkg::wide_t      lhs_reg, rhs_reg;

    // best so far
    spp_pkg::num_t              bnum_reg;
    spp_pkg::den_t              bden_reg;
    logic [spp_pkg::EDGE_W-1:0] bedge_reg;
    logic                       found_reg;

    // output register
    logic                       out_valid_reg;
    logic                       out_found_reg;
    spp_pkg::index_t            out_index_reg;

    logic                         pop_take;
    logic                         out_load;
    logic                         better;
    logic                         near_start;
    logic                         near_end;
    logic [2*spp_pkg::TOL_W-1:0]  tol_sq;
    spp_pkg::prod_t               cross_abs;
    spp_pkg::mul_t                m_dxdx, m_dydy, m_qxdx, m_qydy;
    spp_pkg::mul_t                m_qxdy, m_qydx, m_qxqx, m_qyqy, m_rxrx, m_ryry;

    assign pop_take = pop_valid & pop_ready;
    assign tol_sq   = cfg.tolerance * cfg.tolerance;

    // products of the coordinate differences
    assign m_dxdx = dx_reg * dx_reg;
    assign m_dydy = dy_reg * dy_reg;
    assign m_qxdx = qx_reg * dx_reg;
    assign m_qydy = qy_reg * dy_reg;
    assign m_qxdy = qx_reg * dy_reg;
    assign m_qydx = qy_reg * dx_reg;
    assign m_qxqx = qx_reg * qx_reg;
    assign m_qyqy = qy_reg * qy_reg;
    assign m_rxrx = rx_reg * rx_reg;
    assign m_ryry = ry_reg * ry_reg;

    // projection case: clamp to start (or zero length), clamp to end, interior
    assign near_start = (len_reg == '0) || (dot_reg <= 0);
    assign near_end   = dot_reg >= spp_pkg::prod_t'({2'b00, len_reg});
    assign cross_abs  = cross_reg[spp_pkg::PROD_W-1] ? -cross_reg : cross_reg;

    // num/den < bnum/bden
    assign better = lhs_reg < rhs_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            spp_pkg::ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    if (pop_job.seg)
                        state_next = spp_pkg::ST_PROD;
                    else if (pop_job.pick_end)
                        state_next = spp_pkg::ST_EMIT;
                end
            end
            spp_pkg::ST_PROD:
                state_next = spp_pkg::ST_SEL;
            spp_pkg::ST_SEL:
                state_next = (near_start || near_end) ? spp_pkg::ST_MUL : spp_pkg::ST_SQ;
            spp_pkg::ST_SQ:
                state_next = spp_pkg::ST_MUL;
            spp_pkg::ST_MUL:
                state_next = spp_pkg::ST_SUM;
            spp_pkg::ST_SUM:
                state_next = spp_pkg::ST_CMP;
            spp_pkg::ST_CMP:
                state_next = job_reg.pick_end ? spp_pkg::ST_EMIT : spp_pkg::ST_IDLE;
            spp_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || pick.ready)
                begin
                    out_load   = 1'b1;
                    state_next = spp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = spp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= spp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // best distance and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnum_reg      <= '0;
            bden_reg      <= spp_pkg::DEN_ONE;
            bedge_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_take && pop_job.pick_start)
            begin
                bnum_reg  <= spp_pkg::num_t'(tol_sq);
                bden_reg  <= spp_pkg::DEN_ONE;
                bedge_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (state_reg == spp_pkg::ST_CMP && better)
            begin
                bnum_reg  <= num_reg;
                bden_reg  <= den_reg;
                bedge_reg <= job_reg.edge_id;
                found_reg <= 1'b1;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pick.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            spp_pkg::ST_IDLE:
            begin
                if (pop_take)
                begin
                    job_reg <= pop_job;
                    dx_reg  <= spp_pkg::diff_t'(pop_job.ex) - spp_pkg::diff_t'(pop_job.sx);
                    dy_reg  <= spp_pkg::diff_t'(pop_job.ey) - spp_pkg::diff_t'(pop_job.sy);
                    qx_reg  <= spp_pkg::diff_t'(cfg.query_x) - spp_pkg::diff_t'(pop_job.sx);
                    qy_reg  <= spp_pkg::diff_t'(cfg.query_y) - spp_pkg::diff_t'(pop_job.sy);
                    rx_reg  <= spp_pkg::diff_t'(cfg.query_x) - spp_pkg::diff_t'(pop_job.ex);
                    ry_reg  <= spp_pkg::diff_t'(cfg.query_y) - spp_pkg::diff_t'(pop_job.ey);
                end
            end
            spp_pkg::ST_PROD:
            begin
                len_reg   <= spp_pkg::sq_t'(spp_pkg::prod_t'(m_dxdx) + spp_pkg::prod_t'(m_dydy));
                dot_reg   <= spp_pkg::prod_t'(m_qxdx) + spp_pkg::prod_t'(m_qydy);
                cross_reg <= spp_pkg::prod_t'(m_qxdy) - spp_pkg::prod_t'(m_qydx);
                q2_reg    <= spp_pkg::sq_t'(spp_pkg::prod_t'(m_qxqx) + spp_pkg::prod_t'(m_qyqy));
                r2_reg    <= spp_pkg::sq_t'(spp_pkg::prod_t'(m_rxrx) + spp_pkg::prod_t'(m_ryry));
            end
            spp_pkg::ST_SEL:
            begin
                cabs_reg <= spp_pkg::sq_t'(cross_abs);
                if (near_start)
                begin
                    num_reg <= spp_pkg::num_t'(q2_reg);
                    den_reg <= spp_pkg::DEN_ONE;
                end
                else if (near_end)
                begin
                    num_reg <= spp_pkg::num_t'(r2_reg);
                    den_reg <= spp_pkg::DEN_ONE;
                end
                else
                begin
                    num_reg <= '0;
                    den_reg <= len_reg;
                end
            end
            spp_pkg::ST_SQ:
                num_reg <= cabs_reg * cabs_reg;
            spp_pkg::ST_MUL:
            begin
                // cross products split on the numerator halves
                p1lo_reg <= num_reg[spp_pkg::HALF_W-1:0] * bden_reg;
                p1hi_reg <= num_reg[spp_pkg::NUM_W-1:spp_pkg::HALF_W] * bden_reg;
                p2lo_reg <= bnum_reg[spp_pkg::HALF_W-1:0] * den_reg;
                p2hi_reg <= bnum_reg[spp_pkg::NUM_W-1:spp_pkg::HALF_W] * den_reg;
            end
            spp_pkg::ST_SUM:
            begin
                lhs_reg <= {p1hi_reg, {spp_pkg::HALF_W{1'b0}}} + spp_pkg::wide_t'(p1lo_reg);
                rhs_reg <= {p2hi_reg, {spp_pkg::HALF_W{1'b0}}} + spp_pkg::wide_t'(p2lo_reg);
            end
            spp_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    out_found_reg <= found_reg;
                    out_index_reg <= found_reg ? spp_pkg::index_t'({1'b0, bedge_reg})
                                               : spp_pkg::INDEX_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pick.valid     = out_valid_reg;
    assign pick.found     = out_found_reg;
    assign pick.near_edge = out_index_reg;

endmodule

// ----- rtl/core/screen_polyline_pick_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_polyline_pick_unit
// Nearest-segment pick over a stream of projected screen vertices.
//
//   port      dir  handshake        payload
//   vertex    in   valid/ready      vertex_x, vertex_y, edge_id, visible,
//                                   edge_start, pick_start, pick_end
//   pick      out  valid/ready      found, near_edge
//   cfg_*     in   write enable     cfg_index, cfg_data (query_x/y, tolerance)
//
// The front end takes one vertex per cycle while the 4-entry job queue has room.
// The back end takes a segment job through the states PROD, SEL, MUL, SUM and CMP,
// with SQ after SEL when the projection falls inside it and the cross term is squared;
// a pick end adds EMIT to load the result register. It takes a new job only in IDLE.
// Reset clears the chain, the best distance (0/1, nothing found) and the queue.
// A stalled result holds the back end; the queue absorbs the front until full.
// ----------------------------------------------------------------------------
module screen_polyline_pick_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    spp_vertex_if.sink                      vertex,
    spp_pick_if.source                      pick,
    input  logic                            cfg_we,
    input  logic [spp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spp_pkg::CFG_W-1:0]       cfg_data
);

    spp_pkg::spp_cfg_t cfg_reg, cfg_next;
    spp_pkg::spp_job_t push_job, pop_job;
    logic              push_valid, push_ready;
    logic              pop_valid, pop_ready;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                spp_pkg::CFG_QUERY_X:
                    cfg_next.query_x = spp_pkg::coord_t'(cfg_data[spp_pkg::COORD_W-1:0]);
                spp_pkg::CFG_QUERY_Y:
                    cfg_next.query_y = spp_pkg::coord_t'(cfg_data[spp_pkg::COORD_W-1:0]);
                spp_pkg::CFG_TOLERANCE:
                    cfg_next.tolerance = cfg_data[spp_pkg::TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    spp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vertex),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    spp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    spp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .pick       (pick)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertex chains into screen_polyline_pick_unit and checks every pick
// result. A scoreboard tracks the nearest in-tolerance segment with exact
// rational compares. Directed chain and segment cases run first, then random
// picks under several pick point and tolerance settings. The sender runs in
// bursts and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 64;    // drain time for the 4 queued jobs
    localparam int HOLD_CYCLES   = 300;

    typedef logic [spp_pkg::EDGE_W-1:0] eid_t;

    typedef struct packed {
        spp_pkg::coord_t x;
        spp_pkg::coord_t y;
        eid_t            eid;
        logic            vis;
        logic            es;
        logic            ps;
        logic            pe;
    } vertex_t;

    typedef struct packed {
        logic            found;
        spp_pkg::index_t near_edge;
    } pick_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                          cfg_we;
    logic [spp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [spp_pkg::CFG_W-1:0]     cfg_data;

    spp_vertex_if vtx_ch ();
    spp_pick_if   pick_ch ();

    screen_polyline_pick_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vtx_ch),
        .pick      (pick_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scoreboard copy of registers and pick state
    spp_pkg::coord_t           cfg_qx = '0;
    spp_pkg::coord_t           cfg_qy = '0;
    logic [spp_pkg::TOL_W-1:0] cfg_tol = '0;
    spp_pkg::coord_t           last_x = '0;
    spp_pkg::coord_t           last_y = '0;
    logic                      last_valid = 1'b0;
    logic [63:0]               best_num = 64'd0;
    logic [63:0]               best_den = 64'd1;
    spp_pkg::index_t           best_edge = spp_pkg::INDEX_NONE;
    logic                      best_found = 1'b0;

    pick_result_t pending_picks[$];

    // run statistics and control
    int errors = 0;
    int vertices_sent = 0;
    int results_checked = 0;
    int results_hit = 0;
    int random_settings = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_max = 0;
    logic stall_on = 1'b0;
    int hold_seq = 0;

    always #HALF_PERIOD clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d picks outstanding", $time, pending_picks.size());
            $display("testbench failed");
            $finish;
        end
    end

    // exact squared distance to one segment; keep it if it beats the best
    function automatic void score_segment(input spp_pkg::coord_t sx, input spp_pkg::coord_t sy,
                                          input spp_pkg::coord_t ex, input spp_pkg::coord_t ey,
                                          input eid_t eid);
        longint dx, dy, px, py, len, dot, rx, ry, cr;
        logic [63:0]  num, den;
        logic [127:0] lhs, rhs;
        dx  = longint'(ex) - longint'(sx);
        dy  = longint'(ey) - longint'(sy);
        px  = longint'(cfg_qx) - longint'(sx);
        py  = longint'(cfg_qy) - longint'(sy);
        len = dx * dx + dy * dy;
        dot = px * dx + py * dy;
        den = 64'd1;
        if (len == 0 || dot <= 0)
        begin
            num = px * px + py * py;
        end
        else if (dot >= len)
        begin
            rx  = longint'(cfg_qx) - longint'(ex);
            ry  = longint'(cfg_qy) - longint'(ey);
            num = rx * rx + ry * ry;
        end
        else
        begin
            cr = px * dy - py * dx;
            if (cr < 0)
                cr = -cr;
            // too far to ever beat a tolerance-bounded best
            if (cr >= (longint'(1) << 29))
                return;
            num = cr * cr;
            den = len;
        end
        lhs = 128'(num) * 128'(best_den);
        rhs = 128'(best_num) * 128'(den);
        if (lhs < rhs)
        begin
            best_num   = num;
            best_den   = den;
            best_edge  = spp_pkg::index_t'({1'b0, eid});
            best_found = 1'b1;
        end
    endfunction

    // advance the pick state by one accepted vertex
    function automatic void track_vertex(input vertex_t v);
        pick_result_t res;
        if (v.ps)
        begin
            best_num   = 64'(cfg_tol) * 64'(cfg_tol);
            best_den   = 64'd1;
            best_edge  = spp_pkg::INDEX_NONE;
            best_found = 1'b0;
            last_valid = 1'b0;
        end
        if (v.es)
            last_valid = 1'b0;
        if (!v.vis)
        begin
            last_valid = 1'b0;
        end
        else
        begin
            if (last_valid)
                score_segment(last_x, last_y, v.x, v.y, v.eid);
            last_x     = v.x;
            last_y     = v.y;
            last_valid = 1'b1;
        end
        if (v.pe)
        begin
            res.found     = best_found;
            res.near_edge = best_edge;
            pending_picks.insert(pending_picks.size(), res);
            if (best_found)
                results_hit++;
        end
    endfunction

    function automatic vertex_t vtx(input int x, input int y, input int eid,
                                    input bit vis, input bit es, input bit ps,
                                    input bit pe);
        vertex_t v;
        v.x   = spp_pkg::coord_t'(x);
        v.y   = spp_pkg::coord_t'(y);
        v.eid = eid[spp_pkg::EDGE_W-1:0];
        v.vis = vis;
        v.es  = es;
        v.ps  = ps;
        v.pe  = pe;
        return v;
    endfunction

    function automatic spp_pkg::coord_t near_coord(input spp_pkg::coord_t center,
                                                   input int spread);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < -4096)
            v = -4096;
        if (v > 4095)
            v = 4095;
        return spp_pkg::coord_t'(v);
    endfunction

    // one vertex transfer, with burst gaps in front
    task automatic send_vertex(input vertex_t v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                vtx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        vtx_ch.valid      <= 1'b1;
        vtx_ch.vertex_x   <= v.x;
        vtx_ch.vertex_y   <= v.y;
        vtx_ch.edge_id    <= v.eid;
        vtx_ch.visible    <= v.vis;
        vtx_ch.edge_start <= v.es;
        vtx_ch.pick_start <= v.ps;
        vtx_ch.pick_end   <= v.pe;
        do
            @(posedge clk);
        while (vtx_ch.ready !== 1'b1);
        track_vertex(v);
        vertices_sent++;
    endtask

    // drop valid, let all picks come back, then let the job queue drain
    task automatic wait_idle();
        vtx_ch.valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write pick point and tolerance while the unit is idle
    task automatic program_pick(input int qx, input int qy, input int tol_data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= spp_pkg::CFG_QUERY_X;
        cfg_data  <= qx[spp_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= spp_pkg::CFG_QUERY_Y;
        cfg_data  <= qy[spp_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= spp_pkg::CFG_TOLERANCE;
        cfg_data  <= tol_data[spp_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_qx  = spp_pkg::coord_t'(qx);
        cfg_qy  = spp_pkg::coord_t'(qy);
        cfg_tol = tol_data[spp_pkg::TOL_W-1:0];
    endtask

    // well-formed pick: chains near the pick point with random breaks
    task automatic send_random_pick();
        int n;
        int spread;
        eid_t eid;
        spp_pkg::coord_t lx, ly;
        vertex_t v;
        n = $urandom_range(1, 14);
        case ($urandom_range(0, 4))
            0: spread = 8;
            1: spread = 64;
            2: spread = 512;
            3: spread = 4096;
            default: spread = 8192;
        endcase
        eid = eid_t'($urandom);
        lx  = near_coord(cfg_qx, spread);
        ly  = near_coord(cfg_qy, spread);
        for (int i = 0; i < n; i++)
        begin
            v.es = (i == 0) || ($urandom_range(0, 6) == 0);
            // new tag on an edge start, sometimes mid-chain without one
            if ((v.es && i != 0) || $urandom_range(0, 9) == 0)
                eid = eid_t'($urandom);
            // occasional repeated point gives a zero-length segment
            if ($urandom_range(0, 9) != 0)
            begin
                lx = near_coord(cfg_qx, spread);
                ly = near_coord(cfg_qy, spread);
            end
            v.x   = lx;
            v.y   = ly;
            v.eid = eid;
            v.vis = ($urandom_range(0, 11) != 0);
            v.ps  = (i == 0);
            v.pe  = (i == n - 1);
            send_vertex(v);
        end
    endtask

    // fully random items, flags included
    task automatic send_noise();
        vertex_t v;
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            v.x   = spp_pkg::coord_t'($urandom);
            v.y   = spp_pkg::coord_t'($urandom);
            v.eid = eid_t'($urandom);
            v.vis = 1'($urandom);
            v.es  = 1'($urandom);
            v.ps  = 1'($urandom);
            v.pe  = 1'($urandom);
            send_vertex(v);
        end
    endtask

    // receiver: 16-bit ready patterns, plus a long hold on request
    initial
    begin
        int pat_pos;
        int hold_left;
        int hold_seen;
        logic [15:0] pattern;
        pat_pos   = 0;
        hold_left = 0;
        hold_seen = 0;
        pattern   = '1;
        pick_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (pat_pos == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    pattern = '1;
                else
                    pattern = 16'($urandom) | 16'($urandom);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pick_ch.ready <= 1'b0;
            end
            else if (!stall_on)
                pick_ch.ready <= 1'b1;
            else
                pick_ch.ready <= pattern[pat_pos];
            pat_pos = (pat_pos + 1) % 16;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        pick_result_t want;
        if (rst_n === 1'b1 && pick_ch.valid === 1'b1 && pick_ch.ready === 1'b1)
        begin
            if (pending_picks.size() == 0)
            begin
                $display("%0t: unexpected pick result found %0b edge %0d", $time,
                         pick_ch.found, pick_ch.near_edge);
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                results_checked++;
                if (pick_ch.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $time,
                             want.found, pick_ch.found);
                    errors++;
                end
                if (pick_ch.near_edge !== want.near_edge)
                begin
                    $display("%0t: near_edge expected %0d actual %0d", $time,
                             want.near_edge, pick_ch.near_edge);
                    errors++;
                end
            end
        end
    end

    // picks after reset, before any pick start: best is 0/1, nothing can win
    task automatic test_before_pick();
        send_vertex(vtx(0, 0, 3, 1, 1, 0, 0));
        send_vertex(vtx(0, 10, 3, 1, 0, 0, 0));
        send_vertex(vtx(5, 5, 3, 1, 0, 0, 1));
    endtask

    // interior projection, before-start clamps and an out-of-reach segment
    task automatic test_segment_cases();
        program_pick(0, 0, 100);
        // horizontal segment passing over the pick point
        send_vertex(vtx(-50, 10, 5, 1, 1, 1, 0));
        send_vertex(vtx(50, 10, 5, 1, 0, 0, 1));
        // projection before the start vertex
        send_vertex(vtx(50, 0, 2, 1, 1, 1, 0));
        send_vertex(vtx(150, 0, 2, 1, 0, 0, 1));
        // nothing within reach
        send_vertex(vtx(1000, 1000, 1, 1, 1, 1, 0));
        send_vertex(vtx(2000, 2000, 4, 1, 0, 0, 1));
    endtask

    // chain breaks, tag changes, exact tolerance boundary, pick continuation
    task automatic test_chain_rules();
        // zero-length segment
        send_vertex(vtx(30, 40, 7, 1, 1, 1, 0));
        send_vertex(vtx(30, 40, 7, 1, 0, 0, 0));
        // past the end, distance exactly at tolerance
        send_vertex(vtx(200, 0, 8, 1, 1, 0, 0));
        send_vertex(vtx(100, 0, 8, 1, 0, 0, 0));
        // invisible vertex breaks the chain
        send_vertex(vtx(0, 0, 9, 0, 0, 0, 0));
        send_vertex(vtx(5, 5, 9, 1, 0, 0, 0));
        // tag change without edge start credits the end vertex
        send_vertex(vtx(-5, 5, 10, 1, 0, 0, 0));
        send_vertex(vtx(60, -80, 11, 1, 0, 0, 1));
        // pick end with no pick start keeps the previous best
        send_vertex(vtx(40, 0, 6, 1, 1, 0, 1));
    endtask

    // coordinate and id extremes, single-item pick
    task automatic test_extremes();
        program_pick(-4096, -4096, 4095);
        send_vertex(vtx(4095, 4095, 1023, 1, 1, 1, 0));
        send_vertex(vtx(-4096, 4095, 0, 1, 0, 0, 0));
        send_vertex(vtx(-4096, -4096, 0, 1, 1, 0, 0));
        send_vertex(vtx(4095, -4096, 1023, 1, 0, 0, 1));
        send_vertex(vtx(0, 0, 512, 1, 1, 1, 1));
    endtask

    // random picks under one setting and one idling mode
    task automatic test_random_phase(input int n_items, input int qx, input int qy,
                                     input int tol_data, input int gaps,
                                     input bit stalls, input bit hold);
        int target;
        program_pick(qx, qy, tol_data);
        random_settings++;
        gap_max  = gaps;
        stall_on <= stalls;
        if (hold)
            hold_seq <= hold_seq + 1;
        target = vertices_sent + n_items;
        while (vertices_sent < target)
        begin
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_random_pick();
        end
        wait_idle();
    endtask

    initial
    begin
        int rq_x, rq_y, rq_tol;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= spp_pkg::CFG_QUERY_X;
        cfg_data          <= '0;
        vtx_ch.valid      <= 1'b0;
        vtx_ch.vertex_x   <= '0;
        vtx_ch.vertex_y   <= '0;
        vtx_ch.edge_id    <= '0;
        vtx_ch.visible    <= 1'b0;
        vtx_ch.edge_start <= 1'b0;
        vtx_ch.pick_start <= 1'b0;
        vtx_ch.pick_end   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_pick();
        test_segment_cases();
        test_chain_rules();
        test_extremes();

        rq_x   = int'($urandom_range(0, 8191)) - 4096;
        rq_y   = int'($urandom_range(0, 8191)) - 4096;
        rq_tol = $urandom_range(1, 300);
        test_random_phase(120, rq_x, rq_y, rq_tol, 6, 1'b1, 1'b0);
        // zero tolerance, corner pick point, no idling at all
        test_random_phase(120, -4096, 4095, 0, 0, 1'b0, 1'b0);
        // widest tolerance, heavy stalls and a long receiver hold
        test_random_phase(120, 4095, -4096, 4095, 0, 1'b1, 1'b1);
        rq_x   = int'($urandom_range(0, 8191)) - 4096;
        rq_y   = int'($urandom_range(0, 8191)) - 4096;
        rq_tol = $urandom_range(0, 4095);
        test_random_phase(120, rq_x, rq_y, rq_tol, 10, 1'b1, 1'b0);
        // tolerance write with the unused top data bit set
        test_random_phase(120, 0, 0, 8191, 3, 1'b0, 1'b0);

        wait_idle();
        $display("Covered %0d vertex transfers and %0d pick results (%0d hits)",
                 vertices_sent, results_checked, results_hit);
        $display("over directed chain cases and %0d random settings; %0d mismatches",
                 random_settings, errors);
        if (errors == 0 && pending_picks.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/spp_pkg.sv
rtl/core/spp_vertex_if.sv
rtl/core/spp_pick_if.sv
rtl/core/spp_front.sv
rtl/core/spp_queue.sv
rtl/core/spp_back.sv
rtl/core/screen_polyline_pick_unit.sv
tb/sv/testbench.sv
